// ===== rtl/core/b2a_fmt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary to ASCII number formatter package
// Shared transaction types, operation codes, ASCII constants and the digit
// character function of the number formatter core.
// ----------------------------------------------------------------------------
package b2a_fmt_pkg;

  // Default for the largest minimum width that the core honors.
  localparam int DEF_MAX_WIDTH = 32;

  // Operation codes of the input transaction.
  localparam logic [2:0] OP_UDEC = 3'd0;
  localparam logic [2:0] OP_SDEC = 3'd1;
  localparam logic [2:0] OP_HEX2 = 3'd2;
  localparam logic [2:0] OP_HEX4 = 3'd3;
  localparam logic [2:0] OP_HEX8 = 3'd4;

  // Register index of the fill character on the configuration port.
  localparam int REG_FILL_CHAR = 0;

  // Characters the core produces besides digits.
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_LF      = 8'h0A;
  localparam logic [7:0] FILL_DEFAULT = 8'h20;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_PREP = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  // Input transaction.
  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] value;
    logic [5:0]  min_width;
    logic        crlf;
  } in_t;

  // Output transaction: one character.
  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } out_t;

  // Upper-case digit character for one nibble; decimal digits use the same map.
  function automatic logic [7:0] digit_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + 8'(nib);
    end else begin
      c = 8'h37 + 8'(nib);
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/binary_to_ascii_number_formatter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary to ASCII number formatter core
// Turns a 32-bit value into unsigned or signed decimal or fixed-width hex
// ASCII text, left-padded to a minimum width, with an optional CR LF.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i, in_stall_o, in_data_i) takes one number
//   per transaction. The output channel (out_valid_o, out_stall_i,
//   out_data_o) returns the text one character per transaction, with last set
//   on the final character. Unknown operation codes are accepted and dropped.
//   Decimal conversion runs a shift-add-3 unit once for each bit of the value,
//   and a preparation state then works out the padding; a hex number goes
//   straight from idle to the preparation state. After that one character
//   leaves per cycle while the output is not stalled. The input is stalled from
//   acceptance until the final character is in the output register. A stall
//   on the output holds the output register and pauses the emitter. Reset is
//   asynchronous; it empties the output register, returns the sequencer to
//   idle and sets the fill character to a space. The fill character must be
//   written over the APB port only while the core is idle; the core itself
//   does not enforce this.
// ----------------------------------------------------------------------------
module binary_to_ascii_number_formatter_core #(
  parameter int MAX_WIDTH = b2a_fmt_pkg::DEF_MAX_WIDTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  b2a_fmt_pkg::in_t   in_data_i,
  // Output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output b2a_fmt_pkg::out_t  out_data_o,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int PadW = $clog2(MAX_WIDTH + 3);

  b2a_fmt_pkg::state_e state_q, state_d;

  logic [7:0]       fill_q;
  logic [9:0][3:0]  bcd_q, bcd_d;
  logic [31:0]      bin_q, bin_d;
  logic [4:0]       cnt_q, cnt_d;
  logic             hex_q, hex_d;
  logic             neg_q, neg_d;
  logic [5:0]       minw_q, minw_d;
  logic             crlf_q, crlf_d;
  logic [3:0]       ndig_q, ndig_d;
  logic [PadW-1:0]  pad_q, pad_d;
  logic             sign_q, sign_d;
  logic [3:0]       dig_q, dig_d;
  logic [1:0]       eol_q, eol_d;
  logic             out_valid_q;
  b2a_fmt_pkg::out_t out_q;

  logic             in_acc;
  logic             emit_step;
  logic [9:0][3:0]  adj;
  logic [71:0]      dd_shift;
  logic [3:0]       lead_ndig;
  logic [3:0]       ndig_sel;
  logic [7:0]       len_calc;
  logic [7:0]       w_calc;
  logic [7:0]       pad_calc;
  logic [3:0]       dig_idx;
  logic [7:0]       emit_char;
  logic             emit_last;

  // Configuration register: a single byte at the fill character address.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= b2a_fmt_pkg::FILL_DEFAULT;
    end else if (psel && penable && pwrite && pready &&
                 (paddr == 2'(b2a_fmt_pkg::REG_FILL_CHAR * 4))) begin
      fill_q <= pwdata[7:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = 32'(fill_q);

  // Handshakes.
  assign in_stall_o = (state_q != b2a_fmt_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign emit_step  = (state_q == b2a_fmt_pkg::ST_EMIT) && (!out_valid_q || !out_stall_i);

  // Shared shift-add-3 unit: correct each BCD digit, then shift one bit in.
  always_comb begin
    for (int i = 0; i < 10; i++) begin
      adj[i] = (bcd_q[i] >= 4'd5) ? (bcd_q[i] + 4'd3) : bcd_q[i];
    end
    dd_shift = {adj, bin_q} << 1;
  end

  // Count of significant decimal digits, at least one.
  always_comb begin
    lead_ndig = 4'd1;
    for (int i = 0; i < 10; i++) begin
      if (bcd_q[i] != 4'd0) begin
        lead_ndig = 4'(i + 1);
      end
    end
  end

  // Text length and padding, worked out once the digits are known.
  always_comb begin
    ndig_sel = hex_q ? ndig_q : lead_ndig;
    len_calc = 8'(neg_q) + 8'(ndig_sel) + (crlf_q ? 8'd2 : 8'd0);
    w_calc   = (8'(minw_q) > 8'(MAX_WIDTH)) ? 8'(MAX_WIDTH) : 8'(minw_q);
    w_calc   = w_calc + (crlf_q ? 8'd2 : 8'd0);
    pad_calc = (w_calc > len_calc) ? (w_calc - len_calc) : 8'd0;
  end

  // Character selection: padding, sign, digits from the top, then CR and LF.
  assign dig_idx = dig_q - 4'd1;

  always_comb begin
    pad_d  = pad_q;
    sign_d = sign_q;
    dig_d  = dig_q;
    eol_d  = eol_q;
    if (pad_q != '0) begin
      emit_char = fill_q;
      pad_d     = pad_q - PadW'(1);
    end else if (sign_q) begin
      emit_char = b2a_fmt_pkg::CHAR_MINUS;
      sign_d    = 1'b0;
    end else if (dig_q != 4'd0) begin
      emit_char = b2a_fmt_pkg::digit_char(bcd_q[dig_idx]);
      dig_d     = dig_q - 4'd1;
    end else if (eol_q == 2'd2) begin
      emit_char = b2a_fmt_pkg::CHAR_CR;
      eol_d     = eol_q - 2'd1;
    end else begin
      emit_char = b2a_fmt_pkg::CHAR_LF;
      eol_d     = 2'd0;
    end
    emit_last = (pad_d == '0) && !sign_d && (dig_d == 4'd0) && (eol_d == 2'd0);
    if (state_q == b2a_fmt_pkg::ST_PREP) begin
      pad_d  = pad_calc[PadW-1:0];
      sign_d = neg_q;
      dig_d  = ndig_sel;
      eol_d  = crlf_q ? 2'd2 : 2'd0;
    end else if (!emit_step) begin
      pad_d  = pad_q;
      sign_d = sign_q;
      dig_d  = dig_q;
      eol_d  = eol_q;
    end
  end

  // Sequencer and operand loading.
  always_comb begin
    state_d = state_q;
    bcd_d   = bcd_q;
    bin_d   = bin_q;
    cnt_d   = cnt_q;
    hex_d   = hex_q;
    neg_d   = neg_q;
    minw_d  = minw_q;
    crlf_d  = crlf_q;
    ndig_d  = ndig_q;
    case (state_q)
      b2a_fmt_pkg::ST_IDLE: begin
        if (in_acc) begin
          minw_d = in_data_i.min_width;
          crlf_d = in_data_i.crlf;
          cnt_d  = 5'd0;
          neg_d  = 1'b0;
          case (in_data_i.op)
            b2a_fmt_pkg::OP_UDEC: begin
              hex_d   = 1'b0;
              bin_d   = in_data_i.value;
              bcd_d   = '0;
              state_d = b2a_fmt_pkg::ST_CONV;
            end
            b2a_fmt_pkg::OP_SDEC: begin
              hex_d   = 1'b0;
              neg_d   = in_data_i.value[31];
              bin_d   = in_data_i.value[31] ? (32'd0 - in_data_i.value) : in_data_i.value;
              bcd_d   = '0;
              state_d = b2a_fmt_pkg::ST_CONV;
            end
            b2a_fmt_pkg::OP_HEX2: begin
              hex_d   = 1'b1;
              ndig_d  = 4'd2;
              bcd_d   = 40'(in_data_i.value);
              state_d = b2a_fmt_pkg::ST_PREP;
            end
            b2a_fmt_pkg::OP_HEX4: begin
              hex_d   = 1'b1;
              ndig_d  = 4'd4;
              bcd_d   = 40'(in_data_i.value);
              state_d = b2a_fmt_pkg::ST_PREP;
            end
            b2a_fmt_pkg::OP_HEX8: begin
              hex_d   = 1'b1;
              ndig_d  = 4'd8;
              bcd_d   = 40'(in_data_i.value);
              state_d = b2a_fmt_pkg::ST_PREP;
            end
            default: begin
              state_d = b2a_fmt_pkg::ST_IDLE;
            end
          endcase
        end
      end
      b2a_fmt_pkg::ST_CONV: begin
        bcd_d = dd_shift[71:32];
        bin_d = dd_shift[31:0];
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          state_d = b2a_fmt_pkg::ST_PREP;
        end
      end
      b2a_fmt_pkg::ST_PREP: begin
        state_d = b2a_fmt_pkg::ST_EMIT;
      end
      b2a_fmt_pkg::ST_EMIT: begin
        if (emit_step && emit_last) begin
          state_d = b2a_fmt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = b2a_fmt_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= b2a_fmt_pkg::ST_IDLE;
      cnt_q       <= 5'd0;
      pad_q       <= '0;
      sign_q      <= 1'b0;
      dig_q       <= 4'd0;
      eol_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pad_q   <= pad_d;
      sign_q  <= sign_d;
      dig_q   <= dig_d;
      eol_q   <= eol_d;
      if (emit_step) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    bcd_q  <= bcd_d;
    bin_q  <= bin_d;
    hex_q  <= hex_d;
    neg_q  <= neg_d;
    minw_q <= minw_d;
    crlf_q <= crlf_d;
    ndig_q <= ndig_d;
    if (emit_step) begin
      out_q.out_char <= emit_char;
      out_q.last     <= emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A waiting character that is not the last means the emitter is still busy.
  a_pending_char_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.last) |-> (state_q == b2a_fmt_pkg::ST_EMIT))
    else $error("non-final character waiting while emitter is not active");

  // A valid operation code leaves the idle state on the next cycle.
  a_valid_op_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_data_i.op <= b2a_fmt_pkg::OP_HEX8))
      |=> (state_q != b2a_fmt_pkg::ST_IDLE))
    else $error("accepted number did not start the sequencer");

  // The top BCD digit of a 32-bit value never needs correction.
  a_bcd_top_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == b2a_fmt_pkg::ST_CONV) |-> (bcd_q[9] < 4'd5))
    else $error("top BCD digit out of range during conversion");

  // The remaining digit count never exceeds ten while emitting.
  a_digit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == b2a_fmt_pkg::ST_EMIT) |-> (dig_q <= 4'd10))
    else $error("digit count out of range");

endmodule

// ===== tb/binary_to_ascii_number_formatter_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary to ASCII number formatter core testbench
// Sends numbers in every format to the core and checks each returned
// character against text predicted in the bench. The predictor builds
// decimal, signed decimal and hex text, pads it with the fill character to
// the minimum width and appends the line end. The fill character is changed
// over the APB port between phases and read back. Both channels idle at
// random, apart from one phase of random numbers with steady flow.
// ----------------------------------------------------------------------------
module binary_to_ascii_number_formatter_core_tb;
  import b2a_fmt_pkg::*;

  localparam int          CLK_HALF        = 10;
  localparam int          RESET_CYCLES    = 12;
  localparam int          IDLE_PCT        = 9;
  localparam int          MAX_REPORTS     = 10;
  localparam int          SETTLE_CYCLES   = 100;
  localparam int          WATCHDOG_LIMIT  = 2000;
  localparam int          RANDOM_CHUNK    = 60;
  localparam int          MAX_TEXT_WIDTH  = DEF_MAX_WIDTH;
  localparam logic [1:0]  FILL_ADDR       = 2'(REG_FILL_CHAR * 4);
  localparam logic [2:0]  OP_FIRST_UNUSED = OP_HEX8 + 3'd1;
  localparam logic [2:0]  OP_LAST_CODE    = 3'd7;
  localparam logic [7:0]  DIGIT_ZERO      = 8'h30;
  localparam logic [7:0]  LETTER_A        = 8'h41;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_t         in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_t        out_data_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [1:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  // Characters still owed by the core, oldest first.
  out_t        expected_chars[$];
  logic [7:0]  fill_shadow = FILL_DEFAULT;
  bit          steady_flow = 1'b0;
  int          error_count = 0;
  int          quiet_cycles = 0;

  binary_to_ascii_number_formatter_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Free-running clock.
  always #(CLK_HALF) clk_i = ~clk_i;

  // Receiver back-pressure, off during the steady phase.
  always @(negedge clk_i) begin
    out_stall_i <= !steady_flow && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Counts mismatches and prints the first few in full.
  task automatic note_error(input string msg);
    if (error_count < MAX_REPORTS) begin
      $display("%t ERROR: %s", $realtime, msg);
    end
    error_count++;
  endtask

  // Appends the characters that one number is expected to produce.
  function automatic void predict_text(input in_t item);
    byte unsigned body[$];
    byte unsigned digits[$];
    logic [31:0]  mag;
    logic [3:0]   nib;
    int           ndig;
    int           width;
    int           pad;
    int           total;
    out_t         ch;

    mag  = item.value;
    ndig = 0;
    case (item.op)
      OP_UDEC, OP_SDEC: begin
        if (item.op == OP_SDEC && item.value[31]) begin
          body.push_back(CHAR_MINUS);
          mag = -item.value;
        end
        do begin
          digits.push_front(DIGIT_ZERO + 8'(mag % 10));
          mag = mag / 10;
        end while (mag != 0);
        body = {body, digits};
      end
      OP_HEX2: ndig = 2;
      OP_HEX4: ndig = 4;
      OP_HEX8: ndig = 8;
      default: return;
    endcase

    // Hex text uses only the low nibbles of the value.
    for (int i = ndig - 1; i >= 0; i--) begin
      nib = 4'(item.value >> (4 * i));
      body.push_back((nib < 4'd10) ? DIGIT_ZERO + 8'(nib) : LETTER_A + 8'(nib) - 8'd10);
    end

    width = (item.min_width > MAX_TEXT_WIDTH) ? MAX_TEXT_WIDTH : int'(item.min_width);
    if (item.crlf) begin
      body.push_back(CHAR_CR);
      body.push_back(CHAR_LF);
      width += 2;
    end
    pad   = (width > body.size()) ? width - body.size() : 0;
    total = pad + body.size();
    for (int k = 0; k < total; k++) begin
      ch.out_char = (k < pad) ? fill_shadow : body[k - pad];
      ch.last     = (k == total - 1);
      expected_chars.push_back(ch);
    end
  endfunction

  // Sends one number and records its expected text once it is taken.
  task automatic send_item(input in_t item);
    @(negedge clk_i);
    while (!steady_flow && ($urandom_range(0, 99) < IDLE_PCT)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    predict_text(item);
  endtask

  task automatic send_fields(input logic [2:0] op, input logic [31:0] value,
                             input logic [5:0] min_width, input logic crlf);
    in_t item;
    item.op        = op;
    item.value     = value;
    item.min_width = min_width;
    item.crlf      = crlf;
    send_item(item);
  endtask

  // Drops valid and waits until the core has sent everything and gone quiet.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [1:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read(input logic [1:0] addr, output logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_fill_reg();
    logic [31:0] rd;
    apb_read(FILL_ADDR, rd);
    if (rd[7:0] !== fill_shadow) begin
      note_error($sformatf("fill register read %02h, expected %02h", rd[7:0], fill_shadow));
    end
  endtask

  // Changes the fill character while the core is idle.
  task automatic set_fill_char(input logic [7:0] fill);
    wait_idle();
    apb_write(FILL_ADDR, {24'd0, fill});
    fill_shadow = fill;
    check_fill_reg();
  endtask

  // Values biased toward digit-count and sign boundaries.
  function automatic logic [31:0] pick_value();
    logic [31:0] p;
    p = 32'd1;
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 20);
      1: begin
        repeat ($urandom_range(0, 9)) p = p * 10;
        return p + $urandom_range(0, 2) - 1;
      end
      2: return 32'h8000_0000 + $urandom_range(0, 3) - 2;
      3: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      4: return $urandom() >> $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  // Fill character comes back as the reset value.
  task automatic test_reset_value();
    check_fill_reg();
  endtask

  // Field extremes, every format and the special cases.
  task automatic test_directed();
    send_fields(OP_UDEC, 32'd0, 6'd0, 1'b0);
    send_fields(OP_UDEC, 32'hFFFF_FFFF, 6'd0, 1'b0);
    send_fields(OP_UDEC, 32'd1_000_000_000, 6'd12, 1'b1);
    send_fields(OP_UDEC, 32'd999_999_999, 6'd10, 1'b0);
    send_fields(OP_SDEC, 32'h8000_0000, 6'd0, 1'b0);
    send_fields(OP_SDEC, 32'h7FFF_FFFF, 6'd11, 1'b1);
    send_fields(OP_SDEC, 32'hFFFF_FFFF, 6'd5, 1'b0);
    send_fields(OP_SDEC, 32'd0, 6'd1, 1'b0);
    send_fields(OP_HEX2, 32'hABCD_EF12, 6'd0, 1'b0);
    send_fields(OP_HEX4, 32'h0000_BEEF, 6'd6, 1'b0);
    send_fields(OP_HEX8, 32'hDEAD_BEEF, 6'd0, 1'b1);
    // Text already wider than the minimum width.
    send_fields(OP_HEX8, 32'd0, 6'd3, 1'b0);
    // Widest legal padding, and widths that saturate.
    send_fields(OP_UDEC, 32'd42, 6'd32, 1'b1);
    send_fields(OP_SDEC, 32'h8000_0000, 6'd63, 1'b1);
    send_fields(OP_HEX2, 32'h0000_00FF, 6'd40, 1'b0);
    send_fields(OP_HEX4, 32'h0000_1234, 6'd33, 1'b1);
    // Unknown operations are dropped without output.
    send_fields(OP_FIRST_UNUSED, $urandom(), 6'd20, 1'b1);
    send_fields(OP_FIRST_UNUSED + 3'd1, $urandom(), 6'd63, 1'b0);
    send_fields(OP_LAST_CODE, $urandom(), 6'd5, 1'b1);
    send_fields(OP_UDEC, 32'd7, 6'd1, 1'b0);
  endtask

  // Padding with the two extreme fill characters and an ordinary one.
  task automatic test_fill_chars();
    logic [7:0] fills[3];
    fills = '{8'h00, 8'hFF, 8'h2A};
    foreach (fills[f]) begin
      set_fill_char(fills[f]);
      send_fields(OP_UDEC, 32'd7, 6'd8, 1'b0);
      send_fields(OP_SDEC, -32'sd5, 6'd6, 1'b1);
      send_fields(OP_HEX2, 32'h0000_003C, 6'd4, 1'b0);
    end
  endtask

  // Random numbers in chunks, each with its own fill character.
  task automatic test_random();
    in_t item;
    int  formatted;
    for (int chunk = 0; chunk < 4; chunk++) begin
      set_fill_char(8'($urandom_range(0, 255)));
      steady_flow = (chunk == 2);
      formatted = 0;
      while (formatted < RANDOM_CHUNK) begin
        if ($urandom_range(0, 99) < 8) begin
          item.op = 3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_CODE));
        end else begin
          item.op = 3'($urandom_range(OP_UDEC, OP_HEX8));
          formatted++;
        end
        item.value     = pick_value();
        item.min_width = ($urandom_range(0, 9) < 6) ? 6'($urandom_range(0, 16))
                                                    : 6'($urandom_range(0, 63));
        item.crlf      = 1'($urandom_range(0, 1));
        send_item(item);
      end
    end
    steady_flow = 1'b0;
  endtask

  // Each character taken is compared with the oldest expected one.
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_chars.size() == 0) begin
        note_error($sformatf("unexpected character %02h last %0b",
                             out_data_o.out_char, out_data_o.last));
      end else begin
        want = expected_chars.pop_front();
        if (out_data_o.out_char !== want.out_char || out_data_o.last !== want.last) begin
          note_error($sformatf("char %02h last %0b, expected char %02h last %0b",
                               out_data_o.out_char, out_data_o.last,
                               want.out_char, want.last));
        end
      end
    end
  end

  // Ends a run that stops making progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("binary_to_ascii_number_formatter_core_tb: FAIL");
        $finish;
      end
    end
  end

  // Test sequence.
  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_value();
    test_directed();
    test_fill_chars();
    test_random();
    wait_idle();
    if (error_count == 0) begin
      $display("binary_to_ascii_number_formatter_core_tb: PASS");
    end else begin
      $display("binary_to_ascii_number_formatter_core_tb: FAIL");
    end
    $finish;
  end

endmodule
